[hdl/tard_pkg.sv]
// Shared constants, codes and helpers of the tablet ASCII report decoder.
package tard_pkg;

  // Default line limit and register reset values
  localparam int LINE_LIMIT_DEF = 30;
  localparam logic [7:0] COORD_OFFSET_RST = 8'd120;
  localparam logic [5:0] PRESS_THRESH_RST = 6'd5;

  // Held-state reset values
  localparam logic signed [7:0]  PRESS_MIN_RST = -8'sd10;
  localparam logic signed [7:0]  PRESS_MAX_RST = 8'sd10;
  localparam logic signed [15:0] POS_RST       = 16'sd1024;

  // Pressure window and limits
  localparam logic signed [15:0] Z_HIGH        = 16'sd99;
  localparam logic signed [15:0] Z_LOW         = -16'sd99;
  localparam logic [8:0]         PRESSURE_FULL = 9'd256;

  // Configuration register indexes
  localparam logic CFG_OFFSET    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // Header codes, also the tool type on the output
  localparam logic [1:0] HDR_PSTYLUS = 2'd0;
  localparam logic [1:0] HDR_PUCK    = 2'd1;
  localparam logic [1:0] HDR_SIDE    = 2'd2;
  localparam logic [1:0] HDR_BAD     = 2'd3;

  // Number parser phases
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Output word layout
  localparam int OUT_BITS  = 52;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  // Clamp a wide signed value to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/tablet_ascii_report_decoder_top.sv]
// Tablet ASCII report decoder: byte parser, report decode and restoring pressure divider.
// Each byte is accepted in the idle state, then parsed; ready drops while it is parsed.
// A report-ending byte passes through parse, commit, decode, setup, the restoring divider
// and the output load to a valid result; without a divide it skips the divider, and a bad
// header goes from commit straight to the load; the load waits for the output register to free up.
// Synchronous active-high reset restores all held state and both registers at once.
module tablet_ascii_report_decoder_top #(
  parameter int LINE_LIMIT = tard_pkg::LINE_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream: [7:0] rx_byte, [8] ctrl_key
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,
  // Output stream: [0] status, [2:1] tool_type, [18:3] x_pos, [34:19] y_pos,
  // [43:35] pressure, [51:44] buttons
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tard_pkg::OUT_BYTES*8-1:0]  m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int CountW = $clog2(LINE_LIMIT + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STEP   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_SETUP  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [7:0] coord_offset;
  logic [5:0] press_thresh;

  // Latched input transaction
  logic [7:0] rx_b;
  logic       ctrl_b;

  // Parser state
  logic [CountW-1:0]   byte_count, byte_count_inc;
  logic [1:0]          field_index, field_index_next;
  logic [1:0]          header_code, header_code_next;
  logic [1:0]          number_phase, number_phase_next;
  logic                negative_flag, negative_flag_next;
  logic signed [15:0]  accumulator, accumulator_next;
  logic signed [15:0]  field_values [3];
  logic signed [15:0]  field_values_next [3];

  // Held report state
  logic signed [7:0]   pressure_min, pressure_max;
  logic signed [15:0]  pos_x, pos_y;
  logic [8:0]          pressure_level;
  logic [7:0]          button_state;
  logic                in_range;

  // Divider
  logic [15:0] dq;
  logic [8:0]  rem;
  logic [7:0]  dp;
  logic [3:0]  div_count;
  logic [8:0]  rem_shift, rem_next;
  logic        q_bit;
  logic [15:0] q_next;

  logic [tard_pkg::OUT_BYTES*8-1:0] out_word;

  logic               is_digit, is_space, report_end;
  logic [3:0]         digit_val;
  logic signed [23:0] acc_wide, acc_dig;
  logic signed [15:0] acc_sat;
  logic signed [15:0] ux, uy, z;
  logic signed [9:0]  base_w, dp_w, t_w;
  logic               z_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // Byte classification and digit step
  always_comb begin
    is_digit  = (rx_b >= tard_pkg::CH_ZERO) && (rx_b <= tard_pkg::CH_NINE);
    is_space  = (rx_b == tard_pkg::CH_SPACE) ||
                ((rx_b >= tard_pkg::CH_TAB) && (rx_b <= tard_pkg::CH_CR));
    digit_val = rx_b[3:0];
    acc_wide  = ({{8{accumulator[15]}}, accumulator} <<< 3) +
                ({{8{accumulator[15]}}, accumulator} <<< 1);
    acc_dig   = negative_flag ? acc_wide - $signed({20'd0, digit_val})
                              : acc_wide + $signed({20'd0, digit_val});
    acc_sat   = tard_pkg::sat16(acc_dig);
    byte_count_inc = byte_count + CountW'(1);
    report_end = (rx_b == tard_pkg::CH_LF) || (byte_count_inc >= CountW'(LINE_LIMIT));
  end

  // Parse one byte of the report
  always_comb begin
    field_index_next   = field_index;
    header_code_next   = header_code;
    number_phase_next  = number_phase;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    for (int i = 0; i < 3; i++) begin
      field_values_next[i] = field_values[i];
    end
    if (byte_count == '0) begin
      priority if (rx_b == tard_pkg::CH_BANG) begin
        header_code_next = tard_pkg::HDR_PSTYLUS;
      end else if (rx_b == tard_pkg::CH_STAR) begin
        header_code_next = tard_pkg::HDR_PUCK;
      end else if (rx_b == tard_pkg::CH_HASH) begin
        header_code_next = tard_pkg::HDR_SIDE;
      end else begin
        header_code_next = tard_pkg::HDR_BAD;
      end
      field_index_next   = 2'd0;
      number_phase_next  = tard_pkg::PH_SKIP;
      negative_flag_next = 1'b0;
      accumulator_next   = '0;
      for (int i = 0; i < 3; i++) begin
        field_values_next[i] = '0;
      end
    end else if (rx_b == tard_pkg::CH_COMMA) begin
      // Commit the field in progress, then open the next one; after the last field, stop parsing
      if (field_index != 2'd0) begin
        field_values_next[field_index - 2'd1] = accumulator;
      end
      if (field_index != 2'd3) begin
        field_index_next   = field_index + 2'd1;
        accumulator_next   = '0;
        negative_flag_next = 1'b0;
        number_phase_next  = tard_pkg::PH_SKIP;
      end else begin
        number_phase_next = tard_pkg::PH_DONE;
      end
    end else if (rx_b != tard_pkg::CH_LF && field_index != 2'd0) begin
      unique case (number_phase)
        tard_pkg::PH_SKIP: begin
          priority if (is_space) begin
            number_phase_next = tard_pkg::PH_SKIP;
          end else if (rx_b == tard_pkg::CH_PLUS || rx_b == tard_pkg::CH_MINUS) begin
            negative_flag_next = (rx_b == tard_pkg::CH_MINUS);
            number_phase_next  = tard_pkg::PH_SIGN;
          end else if (is_digit) begin
            number_phase_next = tard_pkg::PH_DIGITS;
            accumulator_next  = acc_sat;
          end else begin
            number_phase_next = tard_pkg::PH_DONE;
          end
        end
        tard_pkg::PH_SIGN, tard_pkg::PH_DIGITS: begin
          if (is_digit) begin
            number_phase_next = tard_pkg::PH_DIGITS;
            accumulator_next  = acc_sat;
          end else begin
            number_phase_next = tard_pkg::PH_DONE;
          end
        end
        tard_pkg::PH_DONE: begin
          number_phase_next = tard_pkg::PH_DONE;
        end
      endcase
    end
  end

  // Report decode arithmetic
  always_comb begin
    z    = field_values[2];
    ux   = tard_pkg::sat16({{8{field_values[0][15]}}, field_values[0]} -
                           $signed({16'd0, coord_offset}));
    uy   = tard_pkg::sat16({{8{field_values[1][15]}}, field_values[1]} -
                           $signed({16'd0, coord_offset}));
    z_ok = (z > tard_pkg::Z_LOW) && (z < tard_pkg::Z_HIGH);
    base_w = {{2{pressure_min[7]}}, pressure_min} + $signed({4'd0, press_thresh});
    dp_w   = {{2{pressure_max[7]}}, pressure_max} - base_w;
    t_w    = z[9:0] - base_w;
  end

  // Restoring divider step
  always_comb begin
    rem_shift = {rem[7:0], dq[15]};
    q_bit     = (rem_shift >= {1'b0, dp});
    rem_next  = q_bit ? rem_shift - {1'b0, dp} : rem_shift;
    q_next    = {dq[14:0], q_bit};
  end

  // Pack the result
  always_comb begin
    out_word = '0;
    out_word[0]     = (header_code == tard_pkg::HDR_BAD);
    out_word[2:1]   = (header_code == tard_pkg::HDR_BAD) ? tard_pkg::HDR_PSTYLUS
                                                         : header_code;
    out_word[18:3]  = pos_x;
    out_word[34:19] = pos_y;
    out_word[43:35] = pressure_level;
    out_word[51:44] = button_state;
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      coord_offset   <= tard_pkg::COORD_OFFSET_RST;
      press_thresh   <= tard_pkg::PRESS_THRESH_RST;
      byte_count     <= '0;
      field_index    <= 2'd0;
      header_code    <= tard_pkg::HDR_PSTYLUS;
      number_phase   <= tard_pkg::PH_SKIP;
      negative_flag  <= 1'b0;
      accumulator    <= '0;
      for (int i = 0; i < 3; i++) begin
        field_values[i] <= '0;
      end
      pressure_min   <= tard_pkg::PRESS_MIN_RST;
      pressure_max   <= tard_pkg::PRESS_MAX_RST;
      pos_x          <= tard_pkg::POS_RST;
      pos_y          <= tard_pkg::POS_RST;
      pressure_level <= '0;
      button_state   <= '0;
      in_range       <= 1'b0;
      div_count      <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tard_pkg::CFG_OFFSET:    coord_offset <= cfg_data;
          tard_pkg::CFG_THRESHOLD: press_thresh <= cfg_data[5:0];
        endcase
      end

      // Drop the result once taken, unless a new one is loaded now
      if (m_axis_tvalid && m_axis_tready && state != ST_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          field_index   <= field_index_next;
          header_code   <= header_code_next;
          number_phase  <= number_phase_next;
          negative_flag <= negative_flag_next;
          accumulator   <= accumulator_next;
          for (int i = 0; i < 3; i++) begin
            field_values[i] <= field_values_next[i];
          end
          byte_count <= report_end ? '0 : byte_count_inc;
          state      <= report_end ? ST_COMMIT : ST_IDLE;
        end
        ST_COMMIT: begin
          // Close the last field and clear the parser for the next report
          if (field_index != 2'd0) begin
            field_values[field_index - 2'd1] <= accumulator;
          end
          field_index   <= 2'd0;
          number_phase  <= tard_pkg::PH_SKIP;
          negative_flag <= 1'b0;
          accumulator   <= '0;
          state <= (header_code == tard_pkg::HDR_BAD) ? ST_FINISH : ST_CALC;
        end
        ST_CALC: begin
          in_range <= (header_code == tard_pkg::HDR_PSTYLUS) && z_ok;
          unique case (header_code)
            tard_pkg::HDR_PSTYLUS: begin
              button_state   <= {6'd0, ctrl_b, 1'b0};
              pressure_level <= '0;
              if (z_ok) begin
                pos_x <= ux;
                pos_y <= uy;
                if (z < $signed({{8{pressure_min[7]}}, pressure_min})) begin
                  pressure_min <= z[7:0];
                end
                if (z > $signed({{8{pressure_max[7]}}, pressure_max})) begin
                  pressure_max <= z[7:0];
                end
              end
            end
            tard_pkg::HDR_SIDE: begin
              if (z != tard_pkg::Z_HIGH) begin
                pos_x        <= ux;
                pos_y        <= uy;
                button_state <= z[7:0];
              end
            end
            tard_pkg::HDR_PUCK: begin
              button_state <= (z != tard_pkg::Z_HIGH) ? {6'd0, z[2], z[1]} : 8'd0;
              if (z != tard_pkg::Z_HIGH) begin
                pos_x <= ux;
                pos_y <= uy;
              end
            end
            tard_pkg::HDR_BAD: begin
              // A bad header never gets here: commit sends it straight to the output load
            end
          endcase
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          // Start the divider only for a pressing stylus
          if (in_range && t_w > 10'sd0 && dp_w > 10'sd0) begin
            dq        <= {t_w[7:0], 8'd0};
            rem       <= '0;
            dp        <= dp_w[7:0];
            div_count <= '0;
            state     <= ST_DIV;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DIV: begin
          rem       <= rem_next;
          dq        <= q_next;
          div_count <= div_count + 4'd1;
          if (div_count == 4'd15) begin
            pressure_level  <= (q_next > {7'd0, tard_pkg::PRESSURE_FULL}) ?
                               tard_pkg::PRESSURE_FULL : q_next[8:0];
            button_state[0] <= 1'b1;
            state           <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Load the output register when it is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rx_b   <= s_axis_tdata[7:0];
      ctrl_b <= s_axis_tdata[8];
    end
    if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= out_word;
    end
  end

`ifndef ASSERT_OFF
  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count < CountW'(LINE_LIMIT))
    else $error("byte count reached the line limit");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> byte_count == '0)
    else $error("byte count not cleared at report end");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_count == 4'd15) |-> q_next <= {7'd0, tard_pkg::PRESSURE_FULL})
    else $error("pressure quotient above full scale");

  a_min_range: assert property (@(posedge clk) disable iff (rst)
    pressure_min <= tard_pkg::PRESS_MIN_RST && pressure_min > -8'sd99)
    else $error("pressure minimum out of range");
`endif

endmodule
